>>> design/assert_macros.svh
// Assertion macros shared by the ARP cache RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on clk, disabled while rst_n is low.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on clk, also during reset.
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARPC_ASSERT(lbl, prop, msg)
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/arpc_pkg.sv
// Shared constants and types for the ARP cache table.
// No dependencies; used by arpc_store and arp_cache_table.
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int SLOT_W = 4;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_LEARN  = 1'b1;

  // Write request into the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } store_wr_t;

  // Registered read data from the entry store
  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } store_rd_t;

endpackage

>>> design/arp_cache_table.sv
// Top level of the ARP cache table: scan sequencer, shared comparator, result register.
// Depends on arpc_pkg, arpc_store and assert_macros.svh.
//
// Usage:
//   Raise start with in_mode, in_protocol_address and in_hw_address; the
//   transaction is taken at a clock edge where start is high and busy is low.
//   Lookup (mode 0) returns the MAC of the lowest valid entry with that
//   address, or a miss. Learn (mode 1) stores the pair in the first slot that
//   is empty or holds that address; with none, slot 0 is overwritten and
//   out_replaced_full is set.
//   The sequencer reads one entry per cycle through the store's registered
//   read port and checks it in the next cycle with one 32-bit comparator.
//   A match ends the scan early; a miss or a full-table learn scans every
//   entry first. The result is registered onto the out_ ports. busy is high
//   for the scan; start is taken at the edge that ends the out_valid cycle,
//   so a new transaction can be accepted while out_valid is high.
//   out_valid is high for exactly one cycle and the receiver cannot stall.
//   Synchronous reset clears all valid bits and returns the sequencer to idle.
`include "assert_macros.svh"
module arp_cache_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [arpc_pkg::IP_W-1:0]    in_protocol_address,
  input  logic [arpc_pkg::MAC_W-1:0]   in_hw_address,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [arpc_pkg::MAC_W-1:0]   out_found_hw_address,
  output logic [arpc_pkg::SLOT_W-1:0]  out_slot,
  output logic                         out_replaced_full
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic mode_r;
  logic [arpc_pkg::IP_W-1:0]  ip_r;
  logic [arpc_pkg::MAC_W-1:0] mac_r;
  logic [arpc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [arpc_pkg::IDX_W-1:0] cmp_idx_r;

  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [arpc_pkg::MAC_W-1:0]  out_mac_r;
  logic [arpc_pkg::SLOT_W-1:0] out_slot_r;
  logic                        out_repl_r;

  logic accept;
  logic rd_en;
  logic cmp_live;
  logic scan_end;
  logic ip_eq;
  logic match;
  logic done;
  logic [arpc_pkg::IDX_W-1:0] fin_idx;
  arpc_pkg::store_wr_t wr;
  arpc_pkg::store_rd_t rd;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign rd_en    = (state_r == ST_SCAN) &&
                    (cnt_r < arpc_pkg::CNT_W'(arpc_pkg::CACHE_ENTRIES));
  assign cmp_live = (state_r == ST_SCAN) && (cnt_r != '0);
  assign scan_end = (state_r == ST_SCAN) &&
                    (cnt_r == arpc_pkg::CNT_W'(arpc_pkg::CACHE_ENTRIES));

  // Shared comparator and match rule per mode
  assign ip_eq = (rd.ip == ip_r);
  assign match = (mode_r == arpc_pkg::MODE_LEARN) ? (!rd.valid || ip_eq)
                                                  : (rd.valid && ip_eq);
  assign done    = (cmp_live && match) || scan_end;
  assign fin_idx = (cmp_live && match) ? cmp_idx_r : '0;

  // Write on a finished learn
  assign wr.en  = done && (mode_r == arpc_pkg::MODE_LEARN);
  assign wr.idx = fin_idx;
  assign wr.ip  = ip_r;
  assign wr.mac = mac_r;

  arpc_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_idx (cnt_r[arpc_pkg::IDX_W-1:0]),
    .wr     (wr),
    .rd     (rd)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + arpc_pkg::CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= done;
    end
  end

  // Hold the transaction and track the entry under compare
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      ip_r   <= in_protocol_address;
      mac_r  <= in_hw_address;
    end
    if (rd_en) begin
      cmp_idx_r <= cnt_r[arpc_pkg::IDX_W-1:0];
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (done) begin
      if (mode_r == arpc_pkg::MODE_LEARN) begin
        out_hit_r  <= 1'b1;
        out_mac_r  <= mac_r;
        out_slot_r <= arpc_pkg::SLOT_W'(fin_idx);
        out_repl_r <= !(cmp_live && match);
      end else if (cmp_live && match) begin
        out_hit_r  <= 1'b1;
        out_mac_r  <= rd.mac;
        out_slot_r <= arpc_pkg::SLOT_W'(cmp_idx_r);
        out_repl_r <= 1'b0;
      end else begin
        out_hit_r  <= 1'b0;
        out_mac_r  <= '0;
        out_slot_r <= '0;
        out_repl_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_found_hw_address = out_mac_r;
  assign out_slot             = out_slot_r;
  assign out_replaced_full    = out_repl_r;

  `ARPC_ASSERT(a_strobe_idle, out_valid |-> !busy, "result strobe while scanning")
  `ARPC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted transaction did not scan")
  `ARPC_ASSERT(a_strobe_after_scan, out_valid |-> $past(busy), "result strobe without scan")
  `ARPC_ASSERT(a_miss_zero, (out_valid && !out_hit) |-> (out_found_hw_address == '0 && out_slot == '0), "miss result not cleared")
  `ARPC_ASSERT(a_replace_slot0, (out_valid && out_replaced_full) |-> (out_hit && out_slot == '0), "replacement not in slot 0")

endmodule

>>> design/arpc_store.sv
// Entry store of the ARP cache: address and MAC memories plus valid bits.
// Depends on arpc_pkg; one write port and one registered read port.
module arpc_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [arpc_pkg::IDX_W-1:0] rd_idx,
  input  arpc_pkg::store_wr_t       wr,
  output arpc_pkg::store_rd_t       rd
);

  logic [arpc_pkg::IP_W-1:0]  ip_mem  [arpc_pkg::CACHE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] mac_mem [arpc_pkg::CACHE_ENTRIES];
  logic [arpc_pkg::CACHE_ENTRIES-1:0] valid_r;
  arpc_pkg::store_rd_t rd_r;

  // Write address and MAC memories
  always_ff @(posedge clk) begin
    if (wr.en) begin
      ip_mem[wr.idx]  <= wr.ip;
      mac_mem[wr.idx] <= wr.mac;
    end
  end

  // Set valid bit on write, clear all at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= 1'b1;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r.valid <= valid_r[rd_idx];
      rd_r.ip    <= ip_mem[rd_idx];
      rd_r.mac   <= mac_mem[rd_idx];
    end
  end

  assign rd = rd_r;

endmodule

>>> dv/tb_arp_cache_table.sv
// Self-checking testbench for arp_cache_table: directed table walk, then random traffic.
// Depends on arpc_pkg and arp_cache_table; replies come from its cache copy or a directed row.
module tb_arp_cache_table;

  typedef struct {
    logic                        hit;
    logic [arpc_pkg::MAC_W-1:0]  hw;
    logic [arpc_pkg::SLOT_W-1:0] slot;
    logic                        repl;
  } arp_reply_t;

  typedef struct {
    logic                       mode;
    logic [arpc_pkg::IP_W-1:0]  ip;
    logic [arpc_pkg::MAC_W-1:0] hw;
    bit                         typed;
    arp_reply_t                 want;
  } arp_req_t;

  localparam int RANDOM_REQS = 900;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_mode;
  logic [arpc_pkg::IP_W-1:0] in_protocol_address;
  logic [arpc_pkg::MAC_W-1:0] in_hw_address;
  logic out_valid;
  logic out_hit;
  logic [arpc_pkg::MAC_W-1:0] out_found_hw_address;
  logic [arpc_pkg::SLOT_W-1:0] out_slot;
  logic out_replaced_full;

  // Shadow copy of the cache contents
  bit                         cache_valid [arpc_pkg::CACHE_ENTRIES];
  logic [arpc_pkg::IP_W-1:0]  cache_ip    [arpc_pkg::CACHE_ENTRIES];
  logic [arpc_pkg::MAC_W-1:0] cache_mac   [arpc_pkg::CACHE_ENTRIES];

  arp_reply_t reply_q[$];
  arp_req_t   directed_q[$];

  int fail_count;
  int replies_seen;
  int n_lookup_hit;
  int n_lookup_miss;
  int n_learn;
  int n_replace;

  arp_cache_table uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_protocol_address (in_protocol_address),
    .in_hw_address       (in_hw_address),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_found_hw_address(out_found_hw_address),
    .out_slot            (out_slot),
    .out_replaced_full   (out_replaced_full)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Resolve one transaction against the shadow cache and update it
  function automatic arp_reply_t resolve_request(logic mode, logic [arpc_pkg::IP_W-1:0] ip,
                                                 logic [arpc_pkg::MAC_W-1:0] hw);
    arp_reply_t r;
    int pick;
    r = '{hit: 1'b0, hw: '0, slot: '0, repl: 1'b0};
    pick = -1;
    if (mode == arpc_pkg::MODE_LOOKUP) begin
      for (int k = 0; k < arpc_pkg::CACHE_ENTRIES; k++)
        if (pick < 0 && cache_valid[k] && cache_ip[k] == ip) pick = k;
      if (pick >= 0) begin
        r.hit  = 1'b1;
        r.hw   = cache_mac[pick];
        r.slot = pick[arpc_pkg::SLOT_W-1:0];
        n_lookup_hit++;
      end else begin
        n_lookup_miss++;
      end
    end else begin
      for (int k = 0; k < arpc_pkg::CACHE_ENTRIES; k++)
        if (pick < 0 && (!cache_valid[k] || cache_ip[k] == ip)) pick = k;
      // No free or matching slot: evict slot 0
      if (pick < 0) begin
        pick   = 0;
        r.repl = 1'b1;
        n_replace++;
      end
      cache_valid[pick] = 1'b1;
      cache_ip[pick]    = ip;
      cache_mac[pick]   = hw;
      r.hit  = 1'b1;
      r.hw   = hw;
      r.slot = pick[arpc_pkg::SLOT_W-1:0];
      n_learn++;
    end
    return r;
  endfunction

  function automatic arp_req_t table_row(logic mode, logic [arpc_pkg::IP_W-1:0] ip,
                                         logic [arpc_pkg::MAC_W-1:0] hw,
                                         bit typed = 1'b0, logic hit = 1'b0,
                                         logic [arpc_pkg::MAC_W-1:0] want_hw = '0,
                                         logic [arpc_pkg::SLOT_W-1:0] slot = '0,
                                         logic repl = 1'b0);
    arp_req_t q;
    q.mode  = mode;
    q.ip    = ip;
    q.hw    = hw;
    q.typed = typed;
    q.want  = '{hit: hit, hw: want_hw, slot: slot, repl: repl};
    return q;
  endfunction

  // Idle length between transactions: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one transaction from a falling edge and hold it until accepted
  task automatic issue(arp_req_t q);
    arp_reply_t r;
    start               = 1'b1;
    in_mode             = q.mode;
    in_protocol_address = q.ip;
    in_hw_address       = q.hw;
    do @(posedge clk); while (busy !== 1'b0);
    r = resolve_request(q.mode, q.ip, q.hw);
    reply_q.push_back(q.typed ? q.want : r);
    @(negedge clk);
  endtask

  // Drop start for a while, scrambling the idle inputs
  task automatic hold_off(int cycles);
    logic [63:0] w;
    if (cycles > 0) begin
      w                   = {$urandom, $urandom};
      start               = 1'b0;
      in_mode             = w[63];
      in_protocol_address = w[31:0];
      in_hw_address       = w[47:0];
      repeat (cycles) @(negedge clk);
    end
  endtask

  function automatic arp_req_t random_request();
    arp_req_t q;
    logic [63:0] w;
    int k;
    int sel;
    w       = {$urandom, $urandom};
    q.mode  = $urandom_range(0, 1) ? arpc_pkg::MODE_LEARN : arpc_pkg::MODE_LOOKUP;
    q.hw    = ($urandom_range(0, 19) == 0) ? {arpc_pkg::MAC_W{w[5]}}
                                           : w[arpc_pkg::MAC_W-1:0];
    q.typed = 1'b0;
    q.want  = '{hit: 1'b0, hw: '0, slot: '0, repl: 1'b0};
    k       = $urandom_range(0, arpc_pkg::CACHE_ENTRIES - 1);
    sel     = $urandom_range(0, 9);
    // Favor resident addresses so lookups hit and learns refresh entries
    if (sel < 5 && cache_valid[k])
      q.ip = cache_ip[k];
    else if (sel < 7 && cache_valid[k])
      q.ip = cache_ip[k] ^ (32'h1 << $urandom_range(0, 31));
    else if (sel == 7)
      q.ip = {arpc_pkg::IP_W{w[63]}};
    else
      q.ip = $urandom;
    return q;
  endfunction

  // Check each reply against the oldest prediction
  always @(posedge clk) begin : check_replies
    arp_reply_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected reply: hit=%b hw=%h slot=%0d repl=%b", out_hit,
                   out_found_hw_address, out_slot, out_replaced_full);
      end else begin
        want = reply_q.pop_front();
        if (out_hit !== want.hit || out_found_hw_address !== want.hw ||
            out_slot !== want.slot || out_replaced_full !== want.repl) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"reply mismatch: expected hit=%b hw=%h slot=%0d repl=%b, ",
                      "got hit=%b hw=%h slot=%0d repl=%b"},
                     want.hit, want.hw, want.slot, want.repl, out_hit,
                     out_found_hw_address, out_slot, out_replaced_full);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("arp_cache_table verification failed");
    $finish;
  end

  initial begin : stimulus
    int waited;
    arp_req_t q;
    start               = 1'b0;
    in_mode             = arpc_pkg::MODE_LOOKUP;
    in_protocol_address = '0;
    in_hw_address       = '0;
    rst_n               = 1'b0;
    fail_count          = 0;
    for (int k = 0; k < arpc_pkg::CACHE_ENTRIES; k++) begin
      cache_valid[k] = 1'b0;
      cache_ip[k]    = '0;
      cache_mac[k]   = '0;
    end

    // Empty cache misses, extreme addresses, refill of slot 0
    directed_q.push_back(table_row(arpc_pkg::MODE_LOOKUP, 32'h0, 48'h1234_5678_9ABC,
                                   1'b1, 1'b0, '0, 4'd0, 1'b0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LOOKUP, '1, '1,
                                   1'b1, 1'b0, '0, 4'd0, 1'b0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LEARN, 32'h0, '0,
                                   1'b1, 1'b1, '0, 4'd0, 1'b0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LEARN, '1, '1,
                                   1'b1, 1'b1, '1, 4'd1, 1'b0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LOOKUP, 32'h0, '1,
                                   1'b1, 1'b1, '0, 4'd0, 1'b0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LOOKUP, '1, '0,
                                   1'b1, 1'b1, '1, 4'd1, 1'b0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LEARN, 32'h0, 48'hA5A5_5A5A_0F0F));
    // Fill the remaining slots
    for (int k = 2; k < arpc_pkg::CACHE_ENTRIES; k++)
      directed_q.push_back(table_row(arpc_pkg::MODE_LEARN, 32'hC0A8_0100 + 32'(k),
                                     {16'h0200, 32'(k)}));
    // Full table: evict slot 0, then the old address there misses
    directed_q.push_back(table_row(arpc_pkg::MODE_LEARN, 32'h0A00_0001, 48'h0242_AC11_0002,
                                   1'b1, 1'b1, 48'h0242_AC11_0002, 4'd0, 1'b1));
    directed_q.push_back(table_row(arpc_pkg::MODE_LOOKUP, 32'h0, '0,
                                   1'b1, 1'b0, '0, 4'd0, 1'b0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LOOKUP,
                                   32'hC0A8_0100 + 32'(arpc_pkg::CACHE_ENTRIES - 1), '0));
    directed_q.push_back(table_row(arpc_pkg::MODE_LEARN, 32'hC0A8_0107, 48'h8000_0000_0001));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_q[i]) begin
      issue(directed_q[i]);
      hold_off(idle_len());
    end

    // Random phase, with bursts that never idle
    for (int n = 0; n < RANDOM_REQS; n++) begin
      q = random_request();
      issue(q);
      if ((n / 64) % 4 != 1) hold_off(idle_len());
    end
    start = 1'b0;

    // Drain outstanding replies, then allow for a stray late one
    waited = 0;
    while (reply_q.size() > 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (24) @(posedge clk);
    fail_count += reply_q.size();

    $display("checked %0d replies: %0d lookup hits, %0d lookup misses",
             replies_seen, n_lookup_hit, n_lookup_miss);
    $display("learns: %0d, of which %0d evicted slot 0 on a full table", n_learn, n_replace);
    if (fail_count == 0)
      $display("arp_cache_table verification clean");
    else
      $display("arp_cache_table verification failed");
    $finish;
  end

endmodule
